// File: sv/pollard_rho_brent_factor_defines.svh
// assertion macros for the factor search block
`ifndef POLLARD_RHO_BRENT_FACTOR_DEFINES_SVH
`define POLLARD_RHO_BRENT_FACTOR_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define PRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/prb_pkg.sv
// shared constants and types for the factor search block
`default_nettype none
package prb_pkg;
    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int StartWidth = 32;
    localparam int StepWidth = 25;
    localparam int StatusWidth = 2;
    localparam logic [StartWidth-1:0] START_RESET = 32'd2;
    localparam logic [StepWidth-1:0] LIMIT_RESET = 25'd65536;

    typedef enum logic [0:0] {
        CFG_START = 1'b0,
        CFG_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [StatusWidth-1:0] {
        ST_PROPER  = 2'd0,
        ST_TRIVIAL = 2'd1,
        ST_LIMIT   = 2'd2
    } status_t;
endpackage
`default_nettype wire

// File: sv/pollard_rho_brent_factor.sv
// pollard rho factor search, brent cycle detection, one shared shift-subtract unit
// steps: reduce the start value mod the number, then per map step the modular square,
// the increment and difference, the euclid remainder steps, then close the gcd and decide;
// a number below two or a zero limit goes straight to the result
// one item at a time: in_ready is low from acceptance until the result is taken
// asynchronous active-low reset clears all state, config regs to defaults
`default_nettype none
`include "pollard_rho_brent_factor_defines.svh"
module pollard_rho_brent_factor
    import prb_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [0:0]             cfg_index,
    input  wire logic [StartWidth-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [31:0]            number,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [31:0]                 factor,
    output logic [StepWidth-1:0]        steps_taken,
    output logic [StatusWidth-1:0]      status
);
    localparam int W = NUMBER_WIDTH;
    localparam int CW = $clog2(W);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MULRED, S_ADD1, S_DIFF, S_GCDCHK, S_REM, S_DECIDE, S_OUT
    } state_t;

    state_t state_reg;
    logic [StartWidth-1:0] start_reg;
    logic [StepWidth-1:0]  limit_reg;
    logic [W-1:0] n_reg, x_reg, saved_reg, a_reg, b_reg, mulb_reg;
    logic [W:0]   acc_reg;
    logic [StepWidth-1:0] steps_reg, pos_reg;
    logic [StepWidth:0]   size_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0] fac_reg;
    logic [StepWidth-1:0] st_reg;
    logic [StatusWidth-1:0] stat_reg;

    // shared unit: shift-left-in-bit, optional addend, then up to two conditional subtracts of the modulus
    logic [W-1:0] sh_mod;
    logic [W+1:0] sh_val;
    logic [W-1:0] sh_in;
    logic sh_bit;
    logic [W-1:0] sh_m;
    logic [W+1:0] sh_add;
    logic [W:0]   sh_res;
    always_comb
    begin
        sh_val = {1'b0, sh_in, sh_bit} + sh_add;
        if (sh_val >= {2'b00, sh_m})
            sh_res = (W+1)'(sh_val - {2'b00, sh_m});
        else
            sh_res = sh_val[W:0];
        if (sh_res >= {1'b0, sh_m})
            sh_mod = W'(sh_res - {1'b0, sh_m});
        else
            sh_mod = sh_res[W-1:0];
    end

    always_comb
    begin
        sh_in = acc_reg[W-1:0];
        sh_bit = 1'b0;
        sh_m = n_reg;
        sh_add = '0;
        unique case (state_reg)
            S_MUL:
            begin
                // double-and-add modular product, msb first
                sh_add = mulb_reg[W-1] ? {2'b00, a_reg} : '0;
            end
            S_MULRED:
            begin
                // reduce x mod n bit by bit
                sh_in = acc_reg[W-1:0];
                sh_bit = a_reg[W-1];
            end
            S_REM:
            begin
                sh_m = b_reg;
                sh_bit = a_reg[W-1];
            end
            default: ;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign factor = fac_reg;
    assign steps_taken = st_reg;
    assign status = stat_reg;

    logic [W-1:0] n_in;
    logic [W-1:0] st_in;
    assign n_in = W'(number);
    assign st_in = W'(start_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= START_RESET;
            limit_reg <= LIMIT_RESET;
            n_reg <= '0;
            x_reg <= '0;
            saved_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
            mulb_reg <= '0;
            acc_reg <= '0;
            steps_reg <= '0;
            pos_reg <= '0;
            size_reg <= '0;
            cnt_reg <= '0;
            fac_reg <= '0;
            st_reg <= '0;
            stat_reg <= ST_PROPER;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_START: start_reg <= cfg_data;
                    CFG_LIMIT: limit_reg <= cfg_data[StepWidth-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        n_reg <= n_in;
                        x_reg <= st_in;
                        saved_reg <= st_in;
                        size_reg <= (StepWidth+1)'(2);
                        pos_reg <= '0;
                        steps_reg <= '0;
                        if (n_in < W'(2))
                        begin
                            fac_reg <= 32'(n_in);
                            st_reg <= '0;
                            stat_reg <= ST_TRIVIAL;
                            state_reg <= S_OUT;
                        end
                        else if (limit_reg == '0)
                        begin
                            fac_reg <= 32'd1;
                            st_reg <= '0;
                            stat_reg <= ST_LIMIT;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            a_reg <= st_in;
                            acc_reg <= '0;
                            cnt_reg <= '0;
                            state_reg <= S_MULRED;
                        end
                    end
                end
                S_MULRED:
                begin
                    // x mod n, then square it
                    if (cnt_reg == CW'(W-1))
                    begin
                        a_reg <= sh_mod;
                        mulb_reg <= sh_mod;
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        acc_reg <= {1'b0, sh_mod};
                        a_reg <= a_reg << 1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_MUL:
                begin
                    acc_reg <= {1'b0, sh_mod};
                    mulb_reg <= mulb_reg << 1;
                    if (cnt_reg == CW'(W-1))
                        state_reg <= S_ADD1;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_ADD1:
                begin
                    if (acc_reg[W-1:0] == n_reg - 1'b1)
                        x_reg <= '0;
                    else
                        x_reg <= acc_reg[W-1:0] + 1'b1;
                    steps_reg <= steps_reg + 1'b1;
                    pos_reg <= pos_reg + 1'b1;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    a_reg <= (x_reg >= saved_reg) ? x_reg - saved_reg : saved_reg - x_reg;
                    b_reg <= n_reg;
                    state_reg <= S_GCDCHK;
                end
                S_GCDCHK:
                begin
                    // euclid: gcd(a, b); swap in remainder until b is zero
                    if (b_reg == '0)
                        state_reg <= S_DECIDE;
                    else
                    begin
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_REM;
                    end
                end
                S_REM:
                begin
                    if (cnt_reg == CW'(W-1))
                    begin
                        a_reg <= b_reg;
                        b_reg <= sh_mod;
                        state_reg <= S_GCDCHK;
                    end
                    else
                    begin
                        acc_reg <= {1'b0, sh_mod};
                        a_reg <= a_reg << 1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    if (a_reg != W'(1))
                    begin
                        fac_reg <= 32'(a_reg);
                        st_reg <= steps_reg;
                        stat_reg <= (a_reg == n_reg) ? ST_TRIVIAL : ST_PROPER;
                        state_reg <= S_OUT;
                    end
                    else if (steps_reg >= limit_reg)
                    begin
                        fac_reg <= 32'd1;
                        st_reg <= steps_reg;
                        stat_reg <= ST_LIMIT;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if ({1'b0, pos_reg} >= size_reg)
                        begin
                            size_reg <= size_reg << 1;
                            pos_reg <= '0;
                            saved_reg <= x_reg;
                        end
                        a_reg <= x_reg;
                        acc_reg <= '0;
                        mulb_reg <= x_reg;
                        cnt_reg <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `PRB_ASSERT_IMP(a_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `PRB_ASSERT_IMP(a_hold, clk, rst_n, out_valid && !out_ready, ##1 out_valid && $stable(factor))
    `PRB_ASSERT_NEXT(a_acc_mod, clk, rst_n, state_reg == S_MUL, acc_reg[W-1:0] < n_reg)
    `PRB_ASSERT_IMP(a_status, clk, rst_n, out_valid, status != 2'd3)
    `PRB_ASSERT_IMP(a_lim, clk, rst_n, out_valid && status == ST_LIMIT, factor == 32'd1)
endmodule
`default_nettype wire

// File: bench/prb_checker.sv
// request monitor, factor search predictor and result comparison
module prb_checker
    import prb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [StartWidth-1:0] cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [31:0]           number,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [31:0]           factor,
    input  wire logic [StepWidth-1:0]  steps_taken,
    input  wire logic [StatusWidth-1:0] status,
    output int                         errors,
    output int                         outstanding
);
    typedef struct packed {
        logic [31:0]           fac;
        logic [StepWidth-1:0]  steps;
        status_t               st;
    } search_result_t;

    search_result_t awaited_results[$];
    logic [StartWidth-1:0] start_copy;
    logic [StepWidth-1:0]  limit_copy;

    // rho walk with brent's doubling runs, saved value refreshed at each run end
    function automatic search_result_t rho_search(input logic [31:0] num);
        search_result_t r;
        longint unsigned n, x, saved, run_len, run_pos, cnt, g, d, a, b, t;
        n = num;
        if (n < 2) begin
            r.fac = num;
            r.steps = '0;
            r.st = ST_TRIVIAL;
            return r;
        end
        x = start_copy;
        saved = x;
        run_len = 2;
        run_pos = 0;
        cnt = 0;
        g = 1;
        while (g == 1 && cnt < limit_copy) begin
            x = ((x % n) * (x % n)) % n;
            x = (x + 1) % n;
            cnt++;
            run_pos++;
            d = (x >= saved) ? x - saved : saved - x;
            a = d;
            b = n;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            g = a;
            if (g == 1 && run_pos >= run_len) begin
                run_len = run_len << 1;
                run_pos = 0;
                saved = x;
            end
        end
        r.fac = g[31:0];
        r.steps = cnt[StepWidth-1:0];
        if (g == 1)
            r.st = ST_LIMIT;
        else if (g == n)
            r.st = ST_TRIVIAL;
        else
            r.st = ST_PROPER;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    assign outstanding = awaited_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        search_result_t e;
        if (!rst_n)
        begin
            start_copy <= START_RESET;
            limit_copy <= LIMIT_RESET;
            errors <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_START)
                    start_copy <= cfg_data;
                else
                    limit_copy <= cfg_data[StepWidth-1:0];
            end
            if (in_valid && in_ready)
                awaited_results.push_back(rho_search(number));
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with no request pending");
                else
                begin
                    e = awaited_results.pop_front();
                    if (factor !== e.fac)
                        report_mismatch($sformatf("factor %0d want %0d", factor, e.fac));
                    if (steps_taken !== e.steps)
                        report_mismatch($sformatf("steps %0d want %0d", steps_taken, e.steps));
                    if (status !== e.st)
                        report_mismatch($sformatf("status %0d want %0d", status, e.st));
                end
            end
        end
    end
endmodule

// File: bench/tb_pollard_rho_brent_factor.sv
// stimulus and verdict for the factor search block
module tb_pollard_rho_brent_factor;
    import prb_pkg::*;

    localparam int CycleLimit = 30000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = CFG_START;
    logic [StartWidth-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [31:0] number = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] factor;
    logic [StepWidth-1:0] steps_taken;
    logic [StatusWidth-1:0] status;
    int errors;
    int outstanding;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic [StepWidth-1:0] cur_limit = LIMIT_RESET;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    pollard_rho_brent_factor uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .number(number), .out_valid(out_valid), .out_ready(out_ready),
        .factor(factor), .steps_taken(steps_taken), .status(status)
    );

    prb_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .number(number), .out_valid(out_valid), .out_ready(out_ready),
        .factor(factor), .steps_taken(steps_taken), .status(status),
        .errors(errors), .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [StartWidth-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (outstanding != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic set_search(input logic [31:0] sv, input logic [StepWidth-1:0] lim);
        drain();
        write_reg(CFG_START, sv);
        write_reg(CFG_LIMIT, {7'd0, lim});
        cur_limit = lim;
    endtask

    // valid held until the request is taken; a gap drops valid first
    task automatic send_number(input logic [31:0] val);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        number <= val;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic finish_sending();
        in_valid <= 1'b0;
    endtask

    // long searches only on small numbers so each stays cheap
    function automatic logic [31:0] pick_number();
        int k;
        k = $urandom_range(99);
        if (k < 4)
            return $urandom_range(1);
        if (cur_limit > 16 || k < 40)
            return $urandom_range(255, 2);
        if (k < 60)
            return $urandom_range(250, 2) * $urandom_range(65000, 2);
        return $urandom;
    endfunction

    initial
    begin
        logic [31:0] directed[10];
        logic [31:0] starts[6];
        logic [StepWidth-1:0] limits[6];
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd15, 32'd91,
                     32'hFFFFFFFF, 32'h80000000, 32'd8051};
        starts = '{32'd0, 32'hFFFFFFFF, 32'd3, $urandom, $urandom, 32'h7FFFFFFF};
        limits = '{25'd1, 25'd16777216, 25'd300, 25'd0, 25'd7, 25'd16};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings first, then the extremes
        foreach (directed[i])
            send_number(directed[i]);
        finish_sending();
        set_search(32'd0, 25'd1);
        send_number(32'hFFFFFFFF);
        send_number(32'd77);
        finish_sending();
        set_search(32'hFFFFFFFF, 25'd0);
        send_number(32'hFFFFFFFF);
        send_number(32'd1);
        finish_sending();
        set_search(32'd1000, 25'd16777216);
        send_number(32'd221);
        send_number(32'd997);
        finish_sending();

        for (int ph = 0; ph < 6; ph++)
        begin
            set_search(starts[ph], limits[ph]);
            send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 46 : 0;
            recv_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 34 : 0;
            for (int i = 0; i < 17; i++)
            begin
                send_number(pick_number());
                if (ph == 2 && i == 8)
                begin
                    // hold off until everything outstanding has returned
                    finish_sending();
                    drain();
                end
            end
            finish_sending();
        end

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+sv
sv/prb_pkg.sv
sv/pollard_rho_brent_factor.sv
bench/prb_checker.sv
bench/tb_pollard_rho_brent_factor.sv
